// File: rtl/port_programmed_square_wave_beeper_assert.svh
// assertion macros shared by the beeper checker
`ifndef PORT_PROGRAMMED_SQUARE_WAVE_BEEPER_ASSERT_SVH
`define PORT_PROGRAMMED_SQUARE_WAVE_BEEPER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BEEPER_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("beeper check failed");

// next-cycle implication, disabled during reset
`define BEEPER_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("beeper check failed");

`endif

// File: rtl/beeper_pkg.sv
// shared constants and types for the square wave beeper
package beeper_pkg;

    localparam int DIV_W = 21;
    localparam int CNT_W = $clog2(DIV_W);

    localparam logic [DIV_W-1:0] BEEP_CLOCK = 21'd1193189;

    localparam logic [7:0] PORT_DATA = 8'h42;
    localparam logic [7:0] PORT_CTRL = 8'h43;
    localparam logic [7:0] PORT_SPK  = 8'h61;
    localparam logic [7:0] CTRL_ARM  = 8'hB6;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic REG_SAMPLE_RATE = 1'b0;
    localparam logic REG_AMPLITUDE   = 1'b1;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

// File: rtl/beeper_div.sv
// shared restoring divider, one quotient bit per cycle
module beeper_div
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  beeper_pkg::div_req_t req,
    output beeper_pkg::div_rsp_t rsp
);

    logic [beeper_pkg::DIV_W-1:0] rem_reg, rem_next;
    logic [beeper_pkg::DIV_W-1:0] quo_reg, quo_next;
    logic [beeper_pkg::DIV_W-1:0] dvs_reg;
    logic [beeper_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [beeper_pkg::DIV_W:0]   trial;
    logic                         last_step;

    // partial remainder with next dividend bit, minus divisor
    assign trial     = {rem_reg, quo_reg[beeper_pkg::DIV_W-1]} - {1'b0, dvs_reg};
    assign last_step = (cnt_reg == beeper_pkg::CNT_W'(beeper_pkg::DIV_W - 1));

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[beeper_pkg::DIV_W])
            begin
                rem_next = {rem_reg[beeper_pkg::DIV_W-2:0], quo_reg[beeper_pkg::DIV_W-1]};
                quo_next = {quo_reg[beeper_pkg::DIV_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[beeper_pkg::DIV_W-1:0];
                quo_next = {quo_reg[beeper_pkg::DIV_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg + beeper_pkg::CNT_W'(1);
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (req.start)
        begin
            dvs_reg <= req.divisor;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// File: rtl/beeper_wave.sv
// square wave phase counter and sample former
module beeper_wave
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tick,
    input  logic [1:0]  enable,
    input  logic [14:0] amplitude,
    input  logic [15:0] half_period,
    output logic [15:0] sample
);

    logic [15:0] cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic [15:0] cnt_inc;
    logic        active;

    assign active  = (enable != 2'd0);
    assign cnt_inc = (cnt_reg == 16'hFFFF) ? cnt_reg : cnt_reg + 16'd1;

    always_comb
    begin
        if (!active)
        begin
            sample = '0;
        end
        else if (neg_reg)
        begin
            sample = 16'h0000 - {1'b0, amplitude};
        end
        else
        begin
            sample = {1'b0, amplitude};
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        if (tick && active)
        begin
            if (cnt_inc > half_period)
            begin
                cnt_next = cnt_inc - half_period;
                neg_next = !neg_reg;
            end
            else
            begin
                cnt_next = cnt_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            neg_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            neg_reg <= neg_next;
        end
    end

endmodule

// File: rtl/port_programmed_square_wave_beeper.sv
// top level: port decode, division sequencer and sample output of the beeper
// a port write is taken while idle with no sample waiting; a high divisor byte
// with a nonzero divisor starts two passes of the shared divider (21 steps each,
// tone then half period), and no item is taken until both passes are done
// a tick gives its sample in the output register on the next cycle; the next item
// is taken once the sample has been consumed
// reset (rst_n, async low) clears all control state, sample rate 44100, amplitude 16384
module port_programmed_square_wave_beeper
(
    input  logic        clk,
    input  logic        rst_n,
    // input item stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // port [7:0], data [15:8]
    input  logic        s_tuser,   // op (0 port write, 1 sample tick)
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // sample [15:0], signed
    // configuration writes
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [16:0] cfg_data
);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TONE = 2'd1;   // divider computes tone frequency
    localparam logic [1:0] ST_HALF = 2'd2;   // divider computes samples per tone period

    logic [1:0]  state_reg, state_next;

    // configuration registers
    logic [16:0] sample_rate_reg;
    logic [14:0] amplitude_reg;

    // programmed state
    logic        await_low_reg, await_low_next;
    logic [15:0] divisor_reg, divisor_next;
    logic [20:0] tone_hz_reg, tone_hz_next;
    logic [15:0] half_period_reg, half_period_next;
    logic [1:0]  enable_reg, enable_next;

    // output holding register
    logic        m_tvalid_reg, m_tvalid_next;
    logic [15:0] m_tdata_reg;

    logic [7:0]  in_port;
    logic [7:0]  in_data;
    logic        accept;
    logic        tick;
    logic [15:0] wave_sample;
    logic [15:0] div_or;

    beeper_pkg::div_req_t div_req;
    beeper_pkg::div_rsp_t div_rsp;

    assign in_port = s_tdata[7:0];
    assign in_data = s_tdata[15:8];

    // take items only when idle and the last sample has left
    assign s_tready = (state_reg == ST_IDLE) && !m_tvalid_reg;
    assign accept   = s_tvalid && s_tready;
    assign tick     = accept && (s_tuser == beeper_pkg::OP_TICK);

    // high byte is ORed into the divisor
    assign div_or = divisor_reg | {in_data, 8'h00};

    always_comb
    begin
        state_next       = state_reg;
        await_low_next   = await_low_reg;
        divisor_next     = divisor_reg;
        tone_hz_next     = tone_hz_reg;
        half_period_next = half_period_reg;
        enable_next      = enable_reg;
        div_req.start    = 1'b0;
        div_req.dividend = beeper_pkg::BEEP_CLOCK;
        div_req.divisor  = {5'b0, div_or};

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (s_tuser == beeper_pkg::OP_WRITE))
                begin
                    if (in_port == beeper_pkg::PORT_DATA)
                    begin
                        if (await_low_reg)
                        begin
                            // low byte replaces the divisor
                            divisor_next   = {8'h00, in_data};
                            await_low_next = 1'b0;
                        end
                        else
                        begin
                            divisor_next = div_or;
                            // zero divisor keeps the old tone and half period
                            if (div_or != 16'd0)
                            begin
                                div_req.start = 1'b1;
                                state_next    = ST_TONE;
                            end
                        end
                    end
                    else if (in_port == beeper_pkg::PORT_CTRL)
                    begin
                        if (in_data == beeper_pkg::CTRL_ARM)
                        begin
                            await_low_next = 1'b1;
                        end
                    end
                    else if (in_port == beeper_pkg::PORT_SPK)
                    begin
                        enable_next = in_data[1:0];
                    end
                end
            end
            ST_TONE:
            begin
                div_req.dividend = {4'b0, sample_rate_reg};
                div_req.divisor  = div_rsp.quotient;
                if (div_rsp.done)
                begin
                    // tone frequency done, reuse the divider for rate / tone
                    tone_hz_next  = div_rsp.quotient;
                    div_req.start = 1'b1;
                    state_next    = ST_HALF;
                end
            end
            ST_HALF:
            begin
                if (div_rsp.done)
                begin
                    half_period_next = div_rsp.quotient[16:1];
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register: load on a tick, clear once taken
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (tick)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            await_low_reg   <= 1'b0;
            divisor_reg     <= '0;
            tone_hz_reg     <= '0;
            half_period_reg <= '0;
            enable_reg      <= '0;
            m_tvalid_reg    <= 1'b0;
            sample_rate_reg <= 17'd44100;
            amplitude_reg   <= 15'd16384;
        end
        else
        begin
            state_reg       <= state_next;
            await_low_reg   <= await_low_next;
            divisor_reg     <= divisor_next;
            tone_hz_reg     <= tone_hz_next;
            half_period_reg <= half_period_next;
            enable_reg      <= enable_next;
            m_tvalid_reg    <= m_tvalid_next;
            if (cfg_we)
            begin
                if (cfg_addr == beeper_pkg::REG_SAMPLE_RATE)
                begin
                    sample_rate_reg <= cfg_data;
                end
                else
                begin
                    amplitude_reg <= cfg_data[14:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick)
        begin
            m_tdata_reg <= wave_sample;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // shared divider for both quotients
    beeper_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // tone phase and sample value
    beeper_wave u_wave
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick        (tick),
        .enable      (enable_reg),
        .amplitude   (amplitude_reg),
        .half_period (half_period_reg),
        .sample      (wave_sample)
    );

endmodule

// File: rtl/beeper_chk.sv
// port-level checker for the square wave beeper, bound to the top level
`include "port_programmed_square_wave_beeper_assert.svh"

module beeper_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a waiting sample is not dropped
    `BEEPER_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)

    // every accepted tick shows a sample on the next cycle
    `BEEPER_ASSERT_NEXT(a_tick_out, clk, rst_n, s_tvalid && s_tready && s_tuser, m_tvalid)

    // no new item while a sample waits
    `BEEPER_ASSERT_IMPL(a_no_take, clk, rst_n, m_tvalid, !s_tready)

    // magnitude never exceeds 32767
    `BEEPER_ASSERT_IMPL(a_range, clk, rst_n, m_tvalid, m_tdata != 16'h8000)

endmodule

bind port_programmed_square_wave_beeper beeper_chk u_chk (.*);

// File: verif/port_programmed_square_wave_beeper_tb.sv
// self-checking testbench for the port programmed square wave beeper
`timescale 1ns / 1ps

module port_programmed_square_wave_beeper_tb;

    // one row of the directed walk; want is only meaningful when typed is set
    typedef struct packed {
        logic        op;
        logic [7:0]  port;
        logic [7:0]  data;
        logic        typed;
        logic [15:0] want;
    } beep_row_t;

    localparam int DIR_ROWS  = 25;
    localparam int SETTLE    = 64;       // covers the two divider passes after a high byte
    localparam int SOAK_TICKS = 200;     // ticks with a zero half period, the count keeps climbing

    logic        clk;
    logic        rst_n;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;          // port [7:0], data [15:8]
    logic        s_tuser  = 1'b0;        // op (0 port write, 1 sample tick)
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;                // sample [15:0], signed
    logic        cfg_we   = 1'b0;
    logic        cfg_addr = 1'b0;
    logic [16:0] cfg_data = '0;

    port_programmed_square_wave_beeper u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    // shadow copy of the beeper state and its two registers
    logic        arm_low;
    logic [15:0] div_word;
    logic [20:0] tone_hz_m;
    logic [15:0] half_per;
    logic [1:0]  spk_en;
    logic [15:0] phase_cnt;
    logic        neg_phase;
    logic [16:0] rate_m;
    logic [14:0] amp_m;

    // samples still owed by the block, oldest first
    logic [15:0] owed_samples [$];
    logic [15:0] want_smp;

    int err_cnt     = 0;
    int tick_cnt    = 0;
    int write_cnt   = 0;
    int div_loads   = 0;
    int checked_cnt = 0;

    // stall mix knobs, in percent of cycles
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    // long output hold-off, counted down by the receiver process
    int rx_hold = 0;

    beep_row_t dir_tbl [DIR_ROWS] = '{
        // disabled after reset: silence
        '{beeper_pkg::OP_TICK,  8'h00, 8'h00, 1'b1, 16'h0000},
        // only the two low bits count as the enable
        '{beeper_pkg::OP_WRITE, beeper_pkg::PORT_SPK, 8'hFC, 1'b0, 16'h0000},
        '{beeper_pkg::OP_TICK,  8'h00, 8'h00, 1'b1, 16'h0000},
        '{beeper_pkg::OP_WRITE, beeper_pkg::PORT_SPK, 8'h03, 1'b0, 16'h0000},
        // half period still zero: sign flips on every tick, positive first
        '{beeper_pkg::OP_TICK,  8'h00, 8'h00, 1'b1, 16'h4000},
        // port and data are ignored on a tick
        '{beeper_pkg::OP_TICK,  8'hFF, 8'hFF, 1'b1, 16'hC000},
        // high byte while the divisor stays zero keeps tone and half period
        '{beeper_pkg::OP_WRITE, beeper_pkg::PORT_DATA, 8'h00, 1'b0, 16'h0000},
        '{beeper_pkg::OP_TICK,  8'h00, 8'h00, 1'b1, 16'h4000},
        // control write other than the arm code, then an undecoded port
        '{beeper_pkg::OP_WRITE, beeper_pkg::PORT_CTRL, 8'h00, 1'b0, 16'h0000},
        '{beeper_pkg::OP_WRITE, 8'h00, 8'hFF, 1'b0, 16'h0000},
        // largest divisor, lowest tone
        '{beeper_pkg::OP_WRITE, beeper_pkg::PORT_CTRL, beeper_pkg::CTRL_ARM, 1'b0, 16'h0000},
        '{beeper_pkg::OP_WRITE, beeper_pkg::PORT_DATA, 8'hFF, 1'b0, 16'h0000},
        '{beeper_pkg::OP_WRITE, beeper_pkg::PORT_DATA, 8'hFF, 1'b0, 16'h0000},
        '{beeper_pkg::OP_TICK,  8'h00, 8'h00, 1'b0, 16'h0000},
        '{beeper_pkg::OP_TICK,  8'h5A, 8'hA5, 1'b0, 16'h0000},
        // smallest nonzero divisor, half period back to zero
        '{beeper_pkg::OP_WRITE, beeper_pkg::PORT_CTRL, beeper_pkg::CTRL_ARM, 1'b0, 16'h0000},
        '{beeper_pkg::OP_WRITE, beeper_pkg::PORT_DATA, 8'h01, 1'b0, 16'h0000},
        '{beeper_pkg::OP_WRITE, beeper_pkg::PORT_DATA, 8'h00, 1'b0, 16'h0000},
        '{beeper_pkg::OP_TICK,  8'h00, 8'h00, 1'b0, 16'h0000},
        // a second high byte ORs into the divisor
        '{beeper_pkg::OP_WRITE, beeper_pkg::PORT_DATA, 8'h80, 1'b0, 16'h0000},
        '{beeper_pkg::OP_TICK,  8'h00, 8'h00, 1'b0, 16'h0000},
        '{beeper_pkg::OP_WRITE, beeper_pkg::PORT_SPK, 8'h01, 1'b0, 16'h0000},
        '{beeper_pkg::OP_TICK,  8'h00, 8'h00, 1'b0, 16'h0000},
        '{beeper_pkg::OP_WRITE, beeper_pkg::PORT_SPK, 8'h02, 1'b0, 16'h0000},
        '{beeper_pkg::OP_TICK,  8'h00, 8'h00, 1'b0, 16'h0000}
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #20_000_000;
        $display("port_programmed_square_wave_beeper regression: fail");
        $finish;
    end

    // receiver: random back-pressure, or a long hold-off when one is requested
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                m_tready <= 1'b0;
                rx_hold = rx_hold - 1;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    // result checker, oldest expectation first
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (owed_samples.size() == 0)
            begin
                $display("%0t: unexpected sample, expected none, actual %h", $time, m_tdata);
                err_cnt++;
            end
            else
            begin
                want_smp = owed_samples.pop_front();
                checked_cnt++;
                if (m_tdata !== want_smp)
                begin
                    $display("%0t: sample mismatch, expected %h, actual %h",
                             $time, want_smp, m_tdata);
                    err_cnt++;
                end
            end
        end
    end

    // advance the shadow state by one item; returns 1 when a sample is owed
    function automatic logic predict_sample(input logic op, input logic [7:0] port,
                                            input logic [7:0] data, output logic [15:0] smp);
        smp = '0;
        if (op == beeper_pkg::OP_WRITE)
        begin
            if (port == beeper_pkg::PORT_DATA)
            begin
                if (arm_low)
                begin
                    div_word = {8'h00, data};
                    arm_low  = 1'b0;
                end
                else
                begin
                    div_word = div_word | {data, 8'h00};
                    // zero divisor keeps the previous tone
                    if (div_word != 16'h0000)
                    begin
                        tone_hz_m = beeper_pkg::BEEP_CLOCK / {5'd0, div_word};
                        half_per  = 16'(({4'd0, rate_m} / tone_hz_m) >> 1);
                    end
                end
            end
            else if (port == beeper_pkg::PORT_CTRL)
            begin
                if (data == beeper_pkg::CTRL_ARM)
                    arm_low = 1'b1;
            end
            else if (port == beeper_pkg::PORT_SPK)
            begin
                spk_en = data[1:0];
            end
            return 1'b0;
        end
        // disabled: silence, counter and phase frozen
        if (spk_en == 2'b00)
            return 1'b1;
        smp = neg_phase ? 16'h0000 - {1'b0, amp_m} : {1'b0, amp_m};
        if (phase_cnt != 16'hFFFF)
            phase_cnt = phase_cnt + 16'd1;
        if (phase_cnt > half_per)
        begin
            phase_cnt = phase_cnt - half_per;
            neg_phase = ~neg_phase;
        end
        return 1'b1;
    endfunction

    // offer one item, wait for the handshake, then book its expected sample
    task automatic send_item(input logic op, input logic [7:0] port, input logic [7:0] data,
                             input logic typed, input logic [15:0] want);
        int          gap;
        logic        owes;
        logic [15:0] smp;
        gap = 0;
        @(negedge clk);
        while (gap < 16 && $urandom_range(0, 99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {data, port};
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        owes = predict_sample(op, port, data, smp);
        if (owes)
        begin
            owed_samples.push_back(typed ? want : smp);
            tick_cnt++;
        end
        else
        begin
            write_cnt++;
        end
    endtask

    task automatic send_tick();
        send_item(beeper_pkg::OP_TICK, 8'($urandom), 8'($urandom), 1'b0, 16'h0000);
    endtask

    task automatic send_write(input logic [7:0] port, input logic [7:0] data);
        send_item(beeper_pkg::OP_WRITE, port, data, 1'b0, 16'h0000);
    endtask

    // drop valid and wait until every owed sample has come back
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (owed_samples.size() != 0)
            @(posedge clk);
    endtask

    // register write only once the block has gone quiet, divider included
    task automatic write_reg(input logic addr, input logic [16:0] val);
        drain();
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= val;
        @(negedge clk);
        cfg_we   <= 1'b0;
        if (addr == beeper_pkg::REG_SAMPLE_RATE)
            rate_m = val;
        else
            amp_m = val[14:0];
    endtask

    // mostly arm/low/high divisor loads and ticks, with broken sequences and noise
    task automatic random_items(input int n, input int hold_at, input int pause_at);
        int         sent;
        int         pick;
        logic [7:0] hi;
        sent = 0;
        while (sent < n)
        begin
            if (hold_at >= 0 && sent >= hold_at)
            begin
                // block fills up behind a stuck receiver
                rx_hold = 300;
                hold_at = -1;
            end
            if (pause_at >= 0 && sent >= pause_at)
            begin
                drain();
                pause_at = -1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                send_tick();
                sent++;
            end
            else if (pick < 70)
            begin
                // small high bytes keep half periods short enough to see many flips
                hi = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
                send_write(beeper_pkg::PORT_CTRL, beeper_pkg::CTRL_ARM);
                send_write(beeper_pkg::PORT_DATA, 8'($urandom));
                send_write(beeper_pkg::PORT_DATA, hi);
                sent += 3;
                div_loads++;
                if ($urandom_range(0, 3) == 0)
                begin
                    send_write(beeper_pkg::PORT_DATA, 8'($urandom));
                    sent++;
                end
            end
            else if (pick < 78)
            begin
                send_write(beeper_pkg::PORT_SPK, 8'($urandom));
                sent++;
            end
            else if (pick < 86)
            begin
                case ($urandom_range(0, 2))
                    0: send_write(beeper_pkg::PORT_CTRL, 8'($urandom));
                    1: send_write(beeper_pkg::PORT_DATA, 8'($urandom));
                    default:
                    begin
                        // armed and low byte given, high byte never comes
                        send_write(beeper_pkg::PORT_CTRL, beeper_pkg::CTRL_ARM);
                        send_write(beeper_pkg::PORT_DATA, 8'($urandom));
                        sent++;
                    end
                endcase
                sent++;
            end
            else
            begin
                send_write(8'($urandom), 8'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        int i;
        rst_n     = 1'b0;
        arm_low   = 1'b0;
        div_word  = '0;
        tone_hz_m = '0;
        half_per  = '0;
        spk_en    = '0;
        phase_cnt = '0;
        neg_phase = 1'b0;
        rate_m    = 17'd44100;
        amp_m     = 15'd16384;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed walk at reset settings
        for (i = 0; i < DIR_ROWS; i++)
            send_item(dir_tbl[i].op, dir_tbl[i].port, dir_tbl[i].data,
                      dir_tbl[i].typed, dir_tbl[i].want);

        // zero half period never pulls the count down, so it keeps climbing
        send_write(beeper_pkg::PORT_CTRL, beeper_pkg::CTRL_ARM);
        send_write(beeper_pkg::PORT_DATA, 8'h01);
        send_write(beeper_pkg::PORT_DATA, 8'h00);
        send_write(beeper_pkg::PORT_SPK, 8'h03);
        for (i = 0; i < SOAK_TICKS; i++)
            send_tick();
        // a real half period now walks the climbed count back down
        send_write(beeper_pkg::PORT_CTRL, beeper_pkg::CTRL_ARM);
        send_write(beeper_pkg::PORT_DATA, 8'hFF);
        send_write(beeper_pkg::PORT_DATA, 8'h10);
        for (i = 0; i < 100; i++)
            send_tick();

        // phase 0: no idling, extremes of rate low and amplitude high, hold-off and pause
        write_reg(beeper_pkg::REG_SAMPLE_RATE, 17'd8000);
        write_reg(beeper_pkg::REG_AMPLITUDE, 17'd32767);
        random_items(400, 150, 280);

        // phase 1: sender idles, highest rate, zero amplitude
        write_reg(beeper_pkg::REG_SAMPLE_RATE, 17'd96000);
        write_reg(beeper_pkg::REG_AMPLITUDE, 17'd0);
        tx_idle_pct = 55;
        random_items(400, -1, -1);

        // phase 2: receiver stalls
        write_reg(beeper_pkg::REG_SAMPLE_RATE, 17'd22050);
        write_reg(beeper_pkg::REG_AMPLITUDE, 17'd1);
        tx_idle_pct  = 0;
        rx_stall_pct = 55;
        random_items(400, -1, -1);

        // phase 3: both sides idle
        write_reg(beeper_pkg::REG_SAMPLE_RATE, 17'($urandom_range(8000, 96000)));
        write_reg(beeper_pkg::REG_AMPLITUDE, 17'($urandom_range(0, 32767)));
        tx_idle_pct  = 21;
        rx_stall_pct = 21;
        random_items(400, -1, -1);

        drain();
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d port writes (%0d random divisor loads) and %0d ticks,",
                 write_cnt, div_loads, tick_cnt);
        $display("checked %0d samples over four stall mixes, a counter climb and rate/amp extremes",
                 checked_cnt);
        if (err_cnt == 0)
            $display("port_programmed_square_wave_beeper regression: pass");
        else
            $display("port_programmed_square_wave_beeper regression: fail");
        $finish;
    end

endmodule

// File: port_programmed_square_wave_beeper.f
+incdir+rtl
rtl/beeper_pkg.sv
rtl/beeper_div.sv
rtl/beeper_wave.sv
rtl/port_programmed_square_wave_beeper.sv
rtl/beeper_chk.sv
verif/port_programmed_square_wave_beeper_tb.sv
